### sv/qte_pkg.sv
// Shared types, widths and constants for the quaternion to ENU heading block.
// Used by qte_vec, qte_cordic and quaternion_to_enu_yaw; depends on nothing.
package qte_pkg;

  // Input components are signed Q1.14.
  localparam int unsigned QUAT_W = 16;
  // Exact product of two components.
  localparam int unsigned PROD_W = 2 * QUAT_W;
  // Sine and cosine parts and the CORDIC vector, with room for the CORDIC gain.
  localparam int unsigned DATA_W = 36;
  // Internal binary angle, 2^32 is one turn.
  localparam int unsigned ANG_W  = 32;
  // Output binary angle, 2^16 is one turn.
  localparam int unsigned HEAD_W = 16;

  // Iteration count; the arctangent table holds 24 entries, so more acts as 24.
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned ATAN_LEN      = 24;
  localparam int unsigned NUM_ITER      =
    (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  // Stages in front of the CORDIC: products, sums, quadrant pre-rotation.
  localparam int unsigned FRONT_STAGES = 3;
  // Registers between an accepted transaction and its result strobe.
  localparam int unsigned LATENCY = FRONT_STAGES + NUM_ITER + 1;

  localparam logic [ANG_W-1:0]  QUARTER_TURN = ANG_W'(64'h4000_0000);
  localparam logic [ANG_W-1:0]  ROUND_HALF   = ANG_W'(64'h0000_8000);
  localparam logic signed [DATA_W-1:0] ONE_Q28 = DATA_W'(64'h1000_0000);

  // Output for a zero vector, where the yaw is taken as zero in both modes.
  localparam logic [HEAD_W-1:0] HEAD_ZERO_YAW = HEAD_W'(16'h4000);

  typedef enum logic {
    MODE_NED = 1'b0,
    MODE_VO  = 1'b1
  } frame_mode_e;

  // Vector travelling down the CORDIC pipeline.
  typedef struct packed {
    logic                     zero;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic        [ANG_W-1:0]  ang;
  } vec_t;

  // round(atan(2^-i) * 2^32 / (2 pi)).
  function automatic logic [ANG_W-1:0] atan_angle(input int unsigned idx);
    logic [ANG_W-1:0] a;
    unique case (idx)
      0:       a = ANG_W'(64'd536870912);
      1:       a = ANG_W'(64'd316933406);
      2:       a = ANG_W'(64'd167458907);
      3:       a = ANG_W'(64'd85004756);
      4:       a = ANG_W'(64'd42667331);
      5:       a = ANG_W'(64'd21354465);
      6:       a = ANG_W'(64'd10679838);
      7:       a = ANG_W'(64'd5340245);
      8:       a = ANG_W'(64'd2670163);
      9:       a = ANG_W'(64'd1335087);
      10:      a = ANG_W'(64'd667544);
      11:      a = ANG_W'(64'd333772);
      12:      a = ANG_W'(64'd166886);
      13:      a = ANG_W'(64'd83443);
      14:      a = ANG_W'(64'd41722);
      15:      a = ANG_W'(64'd20861);
      16:      a = ANG_W'(64'd10430);
      17:      a = ANG_W'(64'd5215);
      18:      a = ANG_W'(64'd2608);
      19:      a = ANG_W'(64'd1304);
      20:      a = ANG_W'(64'd652);
      21:      a = ANG_W'(64'd326);
      22:      a = ANG_W'(64'd163);
      23:      a = ANG_W'(64'd81);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### sv/quaternion_to_enu_yaw.sv
// Quaternion to ENU heading: an accepted transaction passes through the front stages in
// qte_vec, the CORDIC stages and the output register before its result is taken.
// Throughput is one transaction per clock: every stage is a register and busy_o stays
// low, so a new quaternion may be started in every cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets frame_mode to NED.
// Depends on qte_pkg, qte_vec and qte_cordic.
module quaternion_to_enu_yaw (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: frame_mode, written whenever frame_mode_we_i is high.
  input  logic                              frame_mode_we_i,
  input  logic                              frame_mode_i,
  // Command side: a transaction is taken when start_i is high and busy_o low.
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_w_i,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_x_i,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_y_i,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_z_i,
  // Result side: heading_angle_o is valid for the single cycle that done_o is high.
  output logic                              done_o,
  output logic signed [qte_pkg::HEAD_W-1:0] heading_angle_o
);

  qte_pkg::frame_mode_e mode_q;

  logic                 accept;
  logic                 vec_valid;
  qte_pkg::vec_t        vec;
  logic                 rot_valid;
  qte_pkg::vec_t        rot;

  logic [qte_pkg::ANG_W-1:0]  yaw;
  logic [qte_pkg::ANG_W-1:0]  head;
  logic [qte_pkg::ANG_W-1:0]  head_rnd;
  logic                       done_q;
  logic [qte_pkg::HEAD_W-1:0] heading_d, heading_q;

  // The pipeline never backs up, so the block never refuses a transaction.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // The mode register must only be changed by the user while no transaction is in flight;
  // the block itself does not enforce this, and the output stage reads it directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qte_pkg::MODE_NED;
    end else if (frame_mode_we_i) begin
      mode_q <= qte_pkg::frame_mode_e'(frame_mode_i);
    end
  end

  // Products, sine and cosine parts, and the quadrant pre-rotation.
  qte_vec u_vec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .valid_o  (vec_valid),
    .vec_o    (vec)
  );

  // atan2 of the pre-rotated vector, accumulated in the ang field.
  qte_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vec_valid),
    .vec_i   (vec),
    .valid_o (rot_valid),
    .vec_o   (rot)
  );

  // A zero vector has no direction; its yaw is defined as zero. In NED mode the yaw
  // is negated, and both modes add a quarter turn. The 32-bit angle is then rounded
  // to 16 bits by adding half an output step; wrap-around is modulo one turn, so an
  // angle of exactly pi comes out as the most negative code.
  always_comb begin
    yaw = rot.zero ? '0 : rot.ang;
    unique case (mode_q)
      qte_pkg::MODE_NED: head = qte_pkg::QUARTER_TURN - yaw;
      qte_pkg::MODE_VO:  head = qte_pkg::QUARTER_TURN + yaw;
      default:           head = qte_pkg::QUARTER_TURN - yaw;
    endcase
    head_rnd  = head + qte_pkg::ROUND_HALF;
    heading_d = head_rnd[qte_pkg::ANG_W-1 -: qte_pkg::HEAD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rot_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_valid) begin
      heading_q <= heading_d;
    end
  end

  assign done_o          = done_q;
  assign heading_angle_o = heading_q;

`ifndef SYNTHESIS
  // Every vector leaving the CORDIC turns into exactly one result strobe.
  a_cordic_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_valid |=> done_o)
    else $error("CORDIC output did not produce a result strobe");

  // After pre-rotation the vector lies in the right half plane.
  a_prerot_right_half : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_valid |-> !vec.x[qte_pkg::DATA_W-1])
    else $error("pre-rotated vector has negative x");

  // A zero vector yields a heading of a quarter turn in either mode.
  a_zero_vector : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rot_valid && rot.zero) |=> (heading_angle_o == qte_pkg::HEAD_ZERO_YAW))
    else $error("zero vector did not give a quarter-turn heading");

  // No result strobe without a transaction in flight in the CORDIC.
  a_done_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(rot_valid))
    else $error("result strobe without a CORDIC output");
`endif

endmodule

### sv/qte_vec.sv
// Front end: quaternion products, sine and cosine parts, quadrant pre-rotation.
// Three register stages; depends on qte_pkg.
module qte_vec (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_w_i,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_x_i,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_y_i,
  input  logic signed [qte_pkg::QUAT_W-1:0] quat_z_i,
  output logic                             valid_o,
  output qte_pkg::vec_t                    vec_o
);

  logic                              prod_valid_q;
  logic signed [qte_pkg::PROD_W-1:0] wz_q, xy_q, yy_q, zz_q;

  logic                              part_valid_q;
  logic signed [qte_pkg::DATA_W-1:0] sin_d, cos_d, sin_q, cos_q;
  logic signed [qte_pkg::DATA_W-1:0] wz_ext, xy_ext, yy_ext, zz_ext;

  logic                              vec_valid_q;
  qte_pkg::vec_t                     vec_d, vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      part_valid_q <= 1'b0;
      vec_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= valid_i;
      part_valid_q <= prod_valid_q;
      vec_valid_q  <= part_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      wz_q <= qte_pkg::PROD_W'(quat_w_i * quat_z_i);
      xy_q <= qte_pkg::PROD_W'(quat_x_i * quat_y_i);
      yy_q <= qte_pkg::PROD_W'(quat_y_i * quat_y_i);
      zz_q <= qte_pkg::PROD_W'(quat_z_i * quat_z_i);
    end
  end

  assign wz_ext = qte_pkg::DATA_W'(wz_q);
  assign xy_ext = qte_pkg::DATA_W'(xy_q);
  assign yy_ext = qte_pkg::DATA_W'(yy_q);
  assign zz_ext = qte_pkg::DATA_W'(zz_q);

  // Both parts are exact in Q7.28.
  assign sin_d = (wz_ext + xy_ext) <<< 1;
  assign cos_d = qte_pkg::ONE_Q28 - ((yy_ext + zz_ext) <<< 1);

  always_ff @(posedge clk_i) begin
    if (prod_valid_q) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  // A vector in the left half plane is turned by a quarter turn into the right half.
  always_comb begin
    vec_d.zero = (sin_q == '0) && (cos_q == '0);
    if (cos_q < 0) begin
      if (sin_q >= 0) begin
        vec_d.x   = sin_q;
        vec_d.y   = -cos_q;
        vec_d.ang = qte_pkg::QUARTER_TURN;
      end else begin
        vec_d.x   = -sin_q;
        vec_d.y   = cos_q;
        vec_d.ang = '0 - qte_pkg::QUARTER_TURN;
      end
    end else begin
      vec_d.x   = cos_q;
      vec_d.y   = sin_q;
      vec_d.ang = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (part_valid_q) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = vec_valid_q;
  assign vec_o   = vec_q;

endmodule

### sv/qte_cordic.sv
// Pipelined CORDIC in vectoring mode, one register stage per iteration.
// Depends on qte_pkg for the vector type, the iteration count and the angle table.
module qte_cordic (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  qte_pkg::vec_t vec_i,
  output logic          valid_o,
  output qte_pkg::vec_t vec_o
);

  logic [qte_pkg::NUM_ITER-1:0] valid_q;
  qte_pkg::vec_t                pipe_q [qte_pkg::NUM_ITER];

  for (genvar i = 0; i < qte_pkg::NUM_ITER; i++) begin : g_iter
    logic                              in_valid;
    qte_pkg::vec_t                     cur;
    qte_pkg::vec_t                     nxt;
    logic signed [qte_pkg::DATA_W-1:0] xc, yc, xs, ys;

    if (i == 0) begin : g_first
      assign in_valid = valid_i;
      assign cur      = vec_i;
    end else begin : g_next
      assign in_valid = valid_q[i-1];
      assign cur      = pipe_q[i-1];
    end

    assign xc = cur.x;
    assign yc = cur.y;
    // Arithmetic shift rounds toward minus infinity.
    assign xs = xc >>> i;
    assign ys = yc >>> i;

    always_comb begin
      nxt.zero = cur.zero;
      if (yc >= 0) begin
        nxt.x   = xc + ys;
        nxt.y   = yc - xs;
        nxt.ang = cur.ang + qte_pkg::atan_angle(i);
      end else begin
        nxt.x   = xc - ys;
        nxt.y   = yc + xs;
        nxt.ang = cur.ang - qte_pkg::atan_angle(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (in_valid) begin
        pipe_q[i] <= nxt;
      end
    end
  end

  assign valid_o = valid_q[qte_pkg::NUM_ITER-1];
  assign vec_o   = pipe_q[qte_pkg::NUM_ITER-1];

endmodule
